[rtl/stec_pkg.sv]
package stec_pkg;

	localparam int DEPTH_DEF = 16;

	localparam logic [2:0] REQ_SET   = 3'd0;
	localparam logic [2:0] REQ_CLEAR = 3'd1;
	localparam logic [2:0] REQ_CALL  = 3'd2;
	localparam logic [2:0] REQ_TICK  = 3'd3;
	localparam logic [2:0] REQ_STOP  = 3'd4;
	localparam logic [2:0] REQ_START = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_NOTF  = 2'd2;
	localparam logic [1:0] ST_ZERO  = 2'd3;

	localparam logic KIND_CLOSE = 1'b0;
	localparam logic KIND_FIRED = 1'b1;

	typedef struct packed {
		logic [2:0]  req;
		logic        zero_iv;
		logic [23:0] interval;
		logic [7:0]  action;
		logic [31:0] argument;
		logic [3:0]  handle;
	} cmd_t;

	// a is at or before b, modulo 2^32
	function automatic logic not_after(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return !d[31];
	endfunction

endpackage

[rtl/stec_ram.sv]
module stec_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/stec_front.sv]
module stec_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        req_type,
	input  logic [23:0]       interval,
	input  logic [7:0]        action_id,
	input  logic [31:0]       argument,
	input  logic [3:0]        handle,
	output logic              busy,
	output logic              q_avail,
	output stec_pkg::cmd_t    q_data,
	input  logic              q_take
);
	stec_pkg::cmd_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     n_q;
	logic           push;

	assign busy    = (n_q == 2'd2);
	assign push    = start && !busy;
	assign q_avail = (n_q != 2'd0);
	assign q_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{req: req_type, zero_iv: (interval == 24'd0),
				interval: interval, action: action_id, argument: argument,
				handle: handle};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			n_q  <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_take) rp_q <= !rp_q;
			n_q <= n_q + {1'b0, push} - {1'b0, q_take};
		end
	end
endmodule

[rtl/stec_back.sv]
module stec_back #(
	parameter int DEPTH = stec_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [15:0]    own_id,
	input  logic           q_avail,
	input  stec_pkg::cmd_t q_data,
	output logic           q_take,
	output logic           result_valid,
	output logic           kind,
	output logic [1:0]     status,
	output logic [3:0]     slot,
	output logic [7:0]     fired_action,
	output logic [31:0]    fired_argument,
	output logic           last
);
	localparam int SW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FREE   = 4'd1;
	localparam logic [3:0] S_CMP    = 4'd2;
	localparam logic [3:0] S_POSN   = 4'd3;
	localparam logic [3:0] S_INS    = 4'd4;
	localparam logic [3:0] S_HMATCH = 4'd5;
	localparam logic [3:0] S_HSCAN  = 4'd6;
	localparam logic [3:0] S_POP    = 4'd7;
	localparam logic [3:0] S_FIRE   = 4'd8;
	localparam logic [3:0] S_CLOSE  = 4'd9;

	typedef struct packed {
		logic [SW-1:0] slot;
		logic [31:0]   due;
		logic [15:0]   own;
	} ent_t;

	ent_t            list_q [DEPTH];
	ent_t            prv [DEPTH];
	ent_t            nxt [DEPTH];
	logic [DEPTH-1:0] valid_q, flag_q;
	logic [CW-1:0]   count_q, cnt_q;
	logic [3:0]      state_q;
	logic [31:0]     now_q, then_q;
	stec_pkg::cmd_t  cmd_q;
	logic [1:0]      status_q;
	logic [3:0]      cslot_q;
	logic [SW-1:0]   fslot_q;
	logic [SW-1:0]   hslot;
	logic            hnd_ok;
	logic            rm_en, ins_en;
	logic [CW-1:0]   rm_pos;
	logic            pop_go, pop_mine;
	logic [39:0]     rdata;

	assign hslot    = SW'(cmd_q.handle);
	assign hnd_ok   = (int'(cmd_q.handle) < DEPTH);
	assign pop_mine = (list_q[0].own == own_id);
	assign pop_go   = (count_q != '0) &&
		(stec_pkg::not_after(list_q[0].due, now_q) || !pop_mine);
	assign q_take   = (state_q == S_IDLE) && q_avail;

	always_comb begin
		rm_en  = 1'b0;
		rm_pos = '0;
		ins_en = (state_q == S_INS);
		if (state_q == S_POP && pop_go) begin
			rm_en = 1'b1;
		end
		if (state_q == S_HSCAN && cnt_q < count_q && flag_q[cnt_q[SW-1:0]]) begin
			rm_en  = 1'b1;
			rm_pos = cnt_q;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_nb
			if (gi > 0) begin : g_p
				assign prv[gi] = list_q[gi-1];
			end else begin : g_p0
				assign prv[gi] = list_q[gi];
			end
			if (gi + 1 < DEPTH) begin : g_n
				assign nxt[gi] = list_q[gi+1];
			end else begin : g_nl
				assign nxt[gi] = list_q[gi];
			end

			// shift the sorted list for removal or insertion
			always_ff @(posedge clk) begin
				if (rm_en && CW'(gi) >= rm_pos) begin
					list_q[gi] <= nxt[gi];
				end else if (ins_en && CW'(gi) > cnt_q) begin
					list_q[gi] <= prv[gi];
				end else if (ins_en && CW'(gi) == cnt_q) begin
					list_q[gi] <= '{slot: fslot_q, due: then_q, own: own_id};
				end
			end
		end
	endgenerate

	stec_ram #(.W(40), .D(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ins_en),
		.waddr (fslot_q),
		.wdata ({cmd_q.action, cmd_q.argument}),
		.raddr (list_q[0].slot),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_avail) begin
					cmd_q  <= q_data;
					then_q <= now_q + {8'd0, q_data.interval};
				end
			end
			S_CMP: begin
				for (int i = 0; i < DEPTH; i++) begin
					flag_q[i] <= (CW'(i) < count_q) &&
						!stec_pkg::not_after(then_q, list_q[i].due);
				end
			end
			S_HMATCH: begin
				for (int i = 0; i < DEPTH; i++) begin
					flag_q[i] <= (CW'(i) < count_q) && (list_q[i].slot == hslot);
				end
			end
			S_FREE: begin
				fslot_q <= cnt_q[SW-1:0];
			end
			S_POP: begin
				fslot_q <= list_q[0].slot;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			valid_q        <= '0;
			count_q        <= '0;
			cnt_q          <= '0;
			now_q          <= '0;
			status_q       <= stec_pkg::ST_OK;
			cslot_q        <= '0;
			result_valid   <= 1'b0;
			kind           <= stec_pkg::KIND_CLOSE;
			status         <= stec_pkg::ST_OK;
			slot           <= '0;
			fired_action   <= '0;
			fired_argument <= '0;
			last           <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_avail) begin
						status_q <= stec_pkg::ST_OK;
						cslot_q  <= '0;
						cnt_q    <= '0;
						case (q_data.req)
							stec_pkg::REQ_SET: begin
								if (q_data.zero_iv) begin
									status_q <= stec_pkg::ST_ZERO;
									state_q  <= S_POP;
								end else if (int'(count_q) >= DEPTH) begin
									status_q <= stec_pkg::ST_FULL;
									state_q  <= S_POP;
								end else begin
									state_q <= S_FREE;
								end
							end
							stec_pkg::REQ_CLEAR: begin
								status_q <= stec_pkg::ST_NOTF;
								state_q  <= S_HMATCH;
							end
							stec_pkg::REQ_CALL: begin
								valid_q <= '0;
								count_q <= '0;
								state_q <= S_CLOSE;
							end
							stec_pkg::REQ_TICK: begin
								now_q   <= now_q + 32'd1;
								state_q <= S_POP;
							end
							stec_pkg::REQ_START: begin
								state_q <= S_POP;
							end
							default: begin
								state_q <= S_CLOSE;
							end
						endcase
					end
				end
				S_FREE: begin
					if (int'(cnt_q) >= DEPTH) begin
						status_q <= stec_pkg::ST_FULL;
						state_q  <= S_POP;
					end else if (valid_q[cnt_q[SW-1:0]]) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					cnt_q   <= '0;
					state_q <= S_POSN;
				end
				S_POSN: begin
					if (cnt_q < count_q && flag_q[cnt_q[SW-1:0]]) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					count_q          <= count_q + 1'b1;
					valid_q[fslot_q] <= 1'b1;
					cslot_q          <= 4'(fslot_q);
					state_q          <= S_POP;
				end
				S_HMATCH: begin
					cnt_q   <= '0;
					// skip the scan when the handle names no live slot
					state_q <= (hnd_ok && valid_q[hslot]) ? S_HSCAN : S_POP;
				end
				S_HSCAN: begin
					if (cnt_q >= count_q) begin
						state_q <= S_POP;
					end else if (rm_en) begin
						valid_q[hslot] <= 1'b0;
						count_q        <= count_q - 1'b1;
						status_q       <= stec_pkg::ST_OK;
						state_q        <= S_POP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_POP: begin
					if (pop_go) begin
						valid_q[list_q[0].slot] <= 1'b0;
						count_q <= count_q - 1'b1;
						if (pop_mine) state_q <= S_FIRE;
					end else begin
						state_q <= S_CLOSE;
					end
				end
				S_FIRE: begin
					result_valid   <= 1'b1;
					kind           <= stec_pkg::KIND_FIRED;
					status         <= stec_pkg::ST_OK;
					slot           <= 4'(fslot_q);
					fired_action   <= rdata[39:32];
					fired_argument <= rdata[31:0];
					last           <= 1'b0;
					state_q        <= S_POP;
				end
				S_CLOSE: begin
					result_valid   <= 1'b1;
					kind           <= stec_pkg::KIND_CLOSE;
					status         <= status_q;
					slot           <= cslot_q;
					fired_action   <= '0;
					fired_argument <= '0;
					last           <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

[rtl/sorted_timer_event_queue_top.sv]
// Sorted timer queue for up to DEPTH events. A request is taken when start is
// high and busy is low; two requests can wait in the input queue. Each request
// yields zero or more fired words and then one closing word (last high), each
// shown for exactly one cycle on result_valid; the receiver cannot stall.
// Once accepted, a set walks the slot bits for a free slot and then the list
// for its place, one entry a cycle; every fired event passes through a pop
// state and a fire state for the slot data memory read, and every dropped
// foreign event through the pop state only. own_id must be written over the
// APB port only while no request is in flight; the block does not enforce it.
module sorted_timer_event_queue_top #(
	parameter int DEPTH = stec_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [23:0] interval,
	input  logic [7:0]  action_id,
	input  logic [31:0] argument,
	input  logic [3:0]  handle,
	output logic        result_valid,
	output logic        kind,
	output logic [1:0]  status,
	output logic [3:0]  slot,
	output logic [7:0]  fired_action,
	output logic [31:0] fired_argument,
	output logic        last
);
	logic [15:0]    own_id_q;
	logic           q_avail, q_take;
	stec_pkg::cmd_t q_data;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {16'd0, own_id_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			own_id_q <= pwdata[15:0];
		end
	end

	stec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.interval  (interval),
		.action_id (action_id),
		.argument  (argument),
		.handle    (handle),
		.busy      (busy),
		.q_avail   (q_avail),
		.q_data    (q_data),
		.q_take    (q_take)
	);

	stec_back #(.DEPTH(DEPTH)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.own_id         (own_id_q),
		.q_avail        (q_avail),
		.q_data         (q_data),
		.q_take         (q_take),
		.result_valid   (result_valid),
		.kind           (kind),
		.status         (status),
		.slot           (slot),
		.fired_action   (fired_action),
		.fired_argument (fired_argument),
		.last           (last)
	);
endmodule

[rtl/stec_checker.sv]
module stec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        kind,
	input logic [1:0]  status,
	input logic [7:0]  fired_action,
	input logic [31:0] fired_argument,
	input logic        last
);
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last == (kind == stec_pkg::KIND_CLOSE)))
		else $error("last does not match word kind");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == stec_pkg::KIND_FIRED) |-> (status == stec_pkg::ST_OK))
		else $error("fired word with nonzero status");

	a_close_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == stec_pkg::KIND_CLOSE) |->
			(fired_action == 8'd0 && fired_argument == 32'd0))
		else $error("closing word carries event data");

	a_no_fire_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |=> !(result_valid && kind == stec_pkg::KIND_FIRED))
		else $error("fired word right after a closing word");
endmodule

bind sorted_timer_event_queue_top stec_checker u_stec_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.kind           (kind),
	.status         (status),
	.fired_action   (fired_action),
	.fired_argument (fired_argument),
	.last           (last)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int QDEPTH = stec_pkg::DEPTH_DEF;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [23:0] interval;
	logic [7:0]  action_id;
	logic [31:0] argument;
	logic [3:0]  handle;
	logic        result_valid;
	logic        kind;
	logic [1:0]  status;
	logic [3:0]  slot;
	logic [7:0]  fired_action;
	logic [31:0] fired_argument;
	logic        last;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [3:0]  slot;
		logic [7:0]  act;
		logic [31:0] arg;
		logic        lst;
	} timer_word_t;

	sorted_timer_event_queue_top uut (.*);

	// predicted queue state
	logic [31:0] ev_due [QDEPTH];
	logic [7:0]  ev_act [QDEPTH];
	logic [31:0] ev_arg [QDEPTH];
	logic [15:0] ev_own [QDEPTH];
	logic        ev_live [QDEPTH];
	int          due_order [QDEPTH];
	int          n_pending;
	logic [31:0] now_ticks_m;
	logic [15:0] own_id_m;

	timer_word_t pending_words[$];
	int          errors;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#(12 * 600000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic at_or_before(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return !d[31];
	endfunction

	function automatic void drop_head();
		ev_live[due_order[0]] = 1'b0;
		for (int i = 0; i + 1 < n_pending; i++)
			due_order[i] = due_order[i + 1];
		n_pending--;
	endfunction

	// pop every due event and every foreign one from the head
	function automatic void expire_due();
		int s;
		logic mine;
		while (n_pending > 0) begin
			s = due_order[0];
			mine = (ev_own[s] == own_id_m);
			if (!(at_or_before(ev_due[s], now_ticks_m) || !mine))
				break;
			if (mine)
				pending_words.push_back({stec_pkg::KIND_FIRED, stec_pkg::ST_OK, 4'(s),
					ev_act[s], ev_arg[s], 1'b0});
			drop_head();
		end
	endfunction

	function automatic void predict_request(logic [2:0] rq, logic [23:0] iv, logic [7:0] ac,
			logic [31:0] ag, logic [3:0] hd);
		logic [1:0] st;
		logic [3:0] cs;
		logic [31:0] then_t;
		int s;
		int pos;
		st = stec_pkg::ST_OK;
		cs = '0;
		case (rq)
			stec_pkg::REQ_SET: begin
				if (iv == 0) begin
					st = stec_pkg::ST_ZERO;
				end else if (n_pending >= QDEPTH) begin
					st = stec_pkg::ST_FULL;
				end else begin
					s = 0;
					while (s < QDEPTH && ev_live[s])
						s++;
					then_t = now_ticks_m + 32'(iv);
					pos = 0;
					while (pos < n_pending && !at_or_before(then_t, ev_due[due_order[pos]]))
						pos++;
					for (int j = n_pending; j > pos; j--)
						due_order[j] = due_order[j - 1];
					due_order[pos] = s;
					n_pending++;
					ev_due[s] = then_t;
					ev_act[s] = ac;
					ev_arg[s] = ag;
					ev_own[s] = own_id_m;
					ev_live[s] = 1'b1;
					cs = 4'(s);
				end
				expire_due();
			end
			stec_pkg::REQ_CLEAR: begin
				st = stec_pkg::ST_NOTF;
				if (ev_live[hd]) begin
					for (int i = 0; i < n_pending; i++) begin
						if (due_order[i] == hd) begin
							ev_live[hd] = 1'b0;
							for (int k = i; k + 1 < n_pending; k++)
								due_order[k] = due_order[k + 1];
							n_pending--;
							st = stec_pkg::ST_OK;
							break;
						end
					end
				end
				expire_due();
			end
			stec_pkg::REQ_CALL: begin
				for (int i = 0; i < QDEPTH; i++)
					ev_live[i] = 1'b0;
				n_pending = 0;
			end
			stec_pkg::REQ_TICK: begin
				now_ticks_m = now_ticks_m + 1;
				expire_due();
			end
			stec_pkg::REQ_START: expire_due();
			default: ;
		endcase
		pending_words.push_back({stec_pkg::KIND_CLOSE, st, cs, 8'd0, 32'd0, 1'b1});
	endfunction

	// check each word against the oldest expectation
	always @(negedge clk) begin
		timer_word_t got;
		timer_word_t want;
		if (arst_n && result_valid) begin
			got = {kind, status, slot, fired_action, fired_argument, last};
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, got);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (got.kind !== want.kind)
					$display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
				if (got.status !== want.status)
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						got.status);
				if (got.slot !== want.slot)
					$display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
				if (got.act !== want.act)
					$display("%0t: fired_action expected %h actual %h", $time, want.act,
						got.act);
				if (got.arg !== want.arg)
					$display("%0t: fired_argument expected %h actual %h", $time, want.arg,
						got.arg);
				if (got.lst !== want.lst)
					$display("%0t: last expected %0d actual %0d", $time, want.lst, got.lst);
				if (got !== want)
					errors++;
			end
		end
	end

	task automatic send_word(logic [2:0] rq, logic [23:0] iv, logic [7:0] ac,
			logic [31:0] ag, logic [3:0] hd);
		start <= 1'b1;
		req_type <= rq;
		interval <= iv;
		action_id <= ac;
		argument <= ag;
		handle <= hd;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
		end
		@(posedge clk);
		predict_request(rq, iv, ac, ag, hd);
	endtask

	task automatic hold_off(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// wait for every expected word, then let the block drain
	task automatic settle();
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (2 * QDEPTH + 40) @(posedge clk);
	endtask

	task automatic write_own_id(logic [15:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		own_id_m = v;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata[15:0] !== v) begin
			$display("%0t: own_id readback expected %h actual %h", $time, v, prdata[15:0]);
			errors++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_basic_requests();
		send_word(stec_pkg::REQ_START, 0, 0, 0, 0);
		send_word(stec_pkg::REQ_SET, 24'd0, 8'hFF, 32'h7FFFFFFF, 4'd0);
		send_word(stec_pkg::REQ_SET, 24'd1, 8'h00, 32'h80000000, 4'd15);
		send_word(stec_pkg::REQ_SET, 24'd2, 8'hFF, 32'h7FFFFFFF, 4'd0);
		send_word(stec_pkg::REQ_SET, 24'd1, 8'h5A, 32'hFFFFFFFF, 4'd0);
		send_word(stec_pkg::REQ_CLEAR, 0, 0, 0, 4'd15);
		send_word(stec_pkg::REQ_STOP, 0, 0, 0, 0);
		send_word(stec_pkg::REQ_TICK, 0, 0, 0, 0);
		send_word(stec_pkg::REQ_TICK, 0, 0, 0, 0);
		send_word(3'd6, 24'hFFFFFF, 8'hFF, 32'hFFFFFFFF, 4'hF);
		send_word(3'd7, 0, 0, 0, 0);
		send_word(stec_pkg::REQ_CALL, 0, 0, 0, 0);
	endtask

	task automatic test_fill_and_full();
		for (int i = 0; i < QDEPTH; i++)
			send_word(stec_pkg::REQ_SET, 24'hFFFFFF - 24'(i % 3), 8'(i), 32'(i * 7), 4'd0);
		send_word(stec_pkg::REQ_SET, 24'd5, 8'h11, 32'h1, 4'd0);
		send_word(stec_pkg::REQ_CLEAR, 0, 0, 0, 4'd3);
		send_word(stec_pkg::REQ_CLEAR, 0, 0, 0, 4'd3);
		send_word(stec_pkg::REQ_SET, 24'd1, 8'h22, 32'h2, 4'd0);
		send_word(stec_pkg::REQ_TICK, 0, 0, 0, 0);
		send_word(stec_pkg::REQ_CALL, 0, 0, 0, 0);
	endtask

	// events of the old owner are dropped once own_id changes
	task automatic test_owner_purge();
		send_word(stec_pkg::REQ_SET, 24'd3, 8'hA1, 32'h100, 4'd0);
		send_word(stec_pkg::REQ_SET, 24'd1, 8'hA2, 32'h200, 4'd0);
		send_word(stec_pkg::REQ_SET, 24'd900, 8'hA3, 32'h300, 4'd0);
		settle();
		write_own_id(16'h00A5);
		send_word(stec_pkg::REQ_SET, 24'd2, 8'hB1, 32'h400, 4'd0);
		send_word(stec_pkg::REQ_START, 0, 0, 0, 0);
		send_word(stec_pkg::REQ_TICK, 0, 0, 0, 0);
		send_word(stec_pkg::REQ_TICK, 0, 0, 0, 0);
	endtask

	task automatic test_random(int n, bit gaps);
		int r;
		logic [2:0] rq;
		logic [23:0] iv;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 38) rq = stec_pkg::REQ_SET;
			else if (r < 50) rq = stec_pkg::REQ_CLEAR;
			else if (r < 84) rq = stec_pkg::REQ_TICK;
			else if (r < 88) rq = stec_pkg::REQ_START;
			else if (r < 92) rq = stec_pkg::REQ_STOP;
			else if (r < 95) rq = stec_pkg::REQ_CALL;
			else rq = 3'($urandom_range(6, 7));
			r = $urandom_range(0, 19);
			if (r == 0) iv = 24'd0;
			else if (r < 3) iv = 24'($urandom);
			else iv = 24'($urandom_range(1, 6));
			send_word(rq, iv, 8'($urandom), $urandom, 4'($urandom));
			if (gaps && $urandom_range(0, 3) == 0)
				hold_off($urandom_range(1, 18));
		end
	endtask

	initial begin
		errors = 0;
		for (int i = 0; i < QDEPTH; i++)
			ev_live[i] = 1'b0;
		n_pending = 0;
		now_ticks_m = '0;
		own_id_m = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		req_type = '0;
		interval = '0;
		action_id = '0;
		argument = '0;
		handle = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_own_id(16'h0000);
		test_basic_requests();
		settle();
		write_own_id(16'hFFFF);
		test_fill_and_full();
		test_owner_purge();
		settle();
		write_own_id(16'($urandom));
		test_random(45, 1'b1);
		settle();
		write_own_id(16'($urandom));
		test_random(45, 1'b1);
		settle();
		write_own_id(16'hFFFF);
		test_random(40, 1'b0);
		settle();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
